@@ src/ptpm_pkg.sv @@
package ptpm_pkg;

  localparam int MASS_W    = 34;
  localparam int CHG_W     = 4;
  localparam int RT_W      = 24;
  localparam int SEG_W     = 8;
  localparam int TAG_W     = 16;
  localparam int TOL_W     = 17;
  localparam int CNT_OUT_W = 9;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] CFG_TOL      = 2'd0;
  localparam logic [1:0] CFG_RT_START = 2'd1;
  localparam logic [1:0] CFG_RT_END   = 2'd2;

  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_ROTATE = 2'd2;

  // 1e6 * 2 * 100: ppm, the (a+b)/2 mean and the hundredths unit of the tolerance
  localparam logic [27:0] PPM_SCALE = 28'd200000000;

  typedef struct packed {
    logic [1:0]        op;
    logic [MASS_W-1:0] mass;
    logic [CHG_W-1:0]  charge;
    logic [RT_W-1:0]   rt;
    logic [SEG_W-1:0]  segment;
    logic [TAG_W-1:0]  tag;
  } item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [TAG_W-1:0]     found_tag;
    logic [MASS_W-1:0]    found_mass;
    logic [SEG_W-1:0]     found_segment;
    logic [CNT_OUT_W-1:0] entry_count;
  } result_t;

  typedef struct packed {
    logic [MASS_W-1:0] mass;
    logic [CHG_W-1:0]  charge;
    logic [SEG_W-1:0]  segment;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic [1:0] mode;
    entry_t     entry;
  } cell_ctrl_t;

  typedef struct packed {
    logic   vld;
    logic   pass;
    logic   down;
    entry_t entry;
  } match_t;

endpackage

@@ src/ptpm_cell.sv @@
module ptpm_cell #(
  parameter int IDX = 0,
  parameter int CW  = 9
) (
  input  logic                 clk,
  input  ptpm_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]        count,
  input  ptpm_pkg::entry_t     left,
  input  logic                 left_gt,
  input  ptpm_pkg::entry_t     right,
  output ptpm_pkg::entry_t     entry,
  output logic                 gt
);
  import ptpm_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  // table is sorted, so gt is a run of ones from the insert point up to index count - 1
  assign gt = (IDX_C < count) && (entry.mass > ctrl.entry.mass);

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      CELL_INSERT: begin
        if (left_gt) begin
          entry <= left;
        end else if (gt || IDX_C == count) begin
          entry <= ctrl.entry;
        end
      end
      CELL_ROTATE: entry <= right;
      default: ;
    endcase
  end

endmodule

@@ src/ptpm_match.sv @@
module ptpm_match (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              vld,
  input  logic                              down,
  input  ptpm_pkg::entry_t                  head,
  input  logic [ptpm_pkg::MASS_W-1:0]       q_mass,
  input  logic [ptpm_pkg::CHG_W-1:0]        q_charge,
  input  logic [31:0]                       q_t,
  input  logic [ptpm_pkg::TOL_W-1:0]        tol,
  input  logic signed [24:0]                span,
  input  logic                              seg_on,
  output ptpm_pkg::match_t                  res
);
  import ptpm_pkg::*;

  logic [MASS_W-1:0]   diff;
  logic [MASS_W:0]     sum;
  logic signed [9:0]   seg_s;
  logic signed [34:0]  lo;
  logic signed [34:0]  hi;
  logic signed [35:0]  t_s;
  logic                ok;

  logic                sa_vld, sa_down, sa_ok;
  entry_t              sa_entry;
  logic [MASS_W-1:0]   sa_diff;
  logic [MASS_W:0]     sa_sum;

  logic                sb_vld, sb_down, sb_ok;
  entry_t              sb_entry;
  logic [61:0]         sb_pl;
  logic [51:0]         sb_pr;

  always_comb begin
    diff  = (head.mass > q_mass) ? head.mass - q_mass : q_mass - head.mass;
    sum   = {1'b0, head.mass} + {1'b0, q_mass};
    seg_s = {2'b00, head.segment};
    lo    = 35'((seg_s - 10'sd1) * span);
    hi    = 35'(seg_s * span);
    t_s   = $signed({4'b0000, q_t});
    ok    = (head.charge == q_charge) && seg_on && (t_s >= lo) && (t_s <= hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_vld <= 1'b0;
      sb_vld <= 1'b0;
    end else begin
      sa_vld <= vld;
      sb_vld <= sa_vld;
    end
    sa_down  <= down;
    sa_ok    <= ok;
    sa_entry <= head;
    sa_diff  <= diff;
    sa_sum   <= sum;
    sb_down  <= sa_down;
    sb_ok    <= sa_ok;
    sb_entry <= sa_entry;
    sb_pl    <= {28'd0, sa_diff} * {34'd0, PPM_SCALE};
    sb_pr    <= {17'd0, sa_sum} * {35'd0, tol};
  end

  always_comb begin
    res.vld   = sb_vld;
    res.pass  = sb_ok && (sb_pl <= {10'd0, sb_pr});
    res.down  = sb_down;
    res.entry = sb_entry;
  end

endmodule

@@ src/ppm_tolerance_profile_matcher.sv @@
// channel  | handshake      | payload | notes
// item in  | start / busy   | item    | taken when start && !busy
// result   | done (strobe)  | result  | one cycle, one result per item
// config   | cfg_write      | cfg_*   | index 0 tolerance, 1 rt start, 2 rt end
// Insert, clear and unused op: result in the cycle after the item is taken, busy stays low.
// Query: the entry ring rotates once past a single match unit (two-stage multiply
// pipeline), then the drain and report states follow, so the ring length sets the query time.
// Reset clears count, max segment and the rt bounds and sets the tolerance to 1000; entry contents stay undefined.
// The receiver cannot stall: done is a one-cycle strobe.
module ppm_tolerance_profile_matcher #(
  parameter int ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  ptpm_pkg::item_t       item,
  output logic                  done,
  output ptpm_pkg::result_t     result,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [23:0]           cfg_data
);
  import ptpm_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);
  localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_REPORT = 2'd3;

  logic [1:0]        state;
  logic [CW-1:0]     scan_idx;
  logic              drain_cnt;
  logic [CW-1:0]     count;
  logic [SEG_W-1:0]  max_seg;
  logic [TOL_W-1:0]  tol;
  logic [RT_W-1:0]   rt_start;
  logic [RT_W-1:0]   rt_end;
  logic [MASS_W-1:0] q_mass;
  logic [CHG_W-1:0]  q_charge;
  logic [31:0]       q_t;
  logic              seen_ge;
  logic              down_hit, up_hit;
  entry_t            down_ent, up_ent;

  logic              accept;
  cell_ctrl_t        ctrl;
  entry_t            cells [ENTRIES];
  logic              gts   [ENTRIES];
  entry_t            head;
  logic              head_vld, head_lt, head_down;
  logic signed [24:0] span;
  match_t            mres;
  entry_t            new_ent;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign head   = cells[0];
  assign span   = $signed({1'b0, rt_end}) - $signed({1'b0, rt_start});

  always_comb begin
    new_ent.mass    = item.mass;
    new_ent.charge  = item.charge;
    new_ent.segment = item.segment;
    new_ent.tag     = item.tag;
    ctrl.entry      = new_ent;
    if (accept && item.op == OP_INSERT && count != FULL) begin
      ctrl.mode = CELL_INSERT;
    end else if (state == S_SCAN) begin
      ctrl.mode = CELL_ROTATE;
    end else begin
      ctrl.mode = CELL_HOLD;
    end
  end

  genvar i;
  generate
    for (i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_first
        ptpm_cell #(.IDX(i), .CW(CW)) u_cell (
          .clk(clk), .ctrl(ctrl), .count(count),
          .left(cells[ENTRIES-1]), .left_gt(1'b0),
          .right(cells[(i+1) % ENTRIES]),
          .entry(cells[i]), .gt(gts[i])
        );
      end else begin : g_rest
        ptpm_cell #(.IDX(i), .CW(CW)) u_cell (
          .clk(clk), .ctrl(ctrl), .count(count),
          .left(cells[i-1]), .left_gt(gts[i-1]),
          .right(cells[(i+1) % ENTRIES]),
          .entry(cells[i]), .gt(gts[i])
        );
      end
    end
  endgenerate

  // entries up to and including the lower bound search downwards: keep the last pass;
  // entries past it search upwards: keep the first pass
  assign head_vld  = (state == S_SCAN) && (scan_idx < count);
  assign head_lt   = head.mass < q_mass;
  assign head_down = head_lt || !seen_ge;

  ptpm_match u_match (
    .clk(clk), .rst(rst), .vld(head_vld), .down(head_down), .head(head),
    .q_mass(q_mass), .q_charge(q_charge), .q_t(q_t), .tol(tol), .span(span),
    .seg_on(max_seg != '0), .res(mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tol      <= TOL_W'(1000);
      rt_start <= '0;
      rt_end   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TOL:      tol      <= cfg_data[TOL_W-1:0];
        CFG_RT_START: rt_start <= cfg_data;
        CFG_RT_END:   rt_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_idx  <= '0;
      drain_cnt <= 1'b0;
      count     <= '0;
      max_seg   <= '0;
      done      <= 1'b0;
      seen_ge   <= 1'b0;
      down_hit  <= 1'b0;
      up_hit    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (mres.vld && mres.pass) begin
        if (mres.down) begin
          down_hit <= 1'b1;
          down_ent <= mres.entry;
        end else if (!up_hit) begin
          up_hit <= 1'b1;
          up_ent <= mres.entry;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            result.found_tag     <= '0;
            result.found_mass    <= '0;
            result.found_segment <= '0;
            case (item.op)
              OP_INSERT: begin
                done <= 1'b1;
                if (count == FULL) begin
                  result.status      <= ST_FULL;
                  result.entry_count <= CNT_OUT_W'(count);
                end else begin
                  result.status      <= ST_OK;
                  count              <= count + 1'b1;
                  result.entry_count <= CNT_OUT_W'(count + 1'b1);
                  if (item.segment > max_seg) max_seg <= item.segment;
                end
              end
              OP_QUERY: begin
                result.status      <= ST_OK;
                result.entry_count <= CNT_OUT_W'(count);
                state    <= S_SCAN;
                scan_idx <= '0;
                q_mass   <= item.mass;
                q_charge <= item.charge;
                q_t      <= 32'(item.rt) * 32'(max_seg);
                seen_ge  <= 1'b0;
                down_hit <= 1'b0;
                up_hit   <= 1'b0;
              end
              OP_CLEAR: begin
                done               <= 1'b1;
                count              <= '0;
                max_seg            <= '0;
                result.status      <= ST_OK;
                result.entry_count <= '0;
              end
              default: begin
                done               <= 1'b1;
                result.status      <= ST_OK;
                result.entry_count <= CNT_OUT_W'(count);
              end
            endcase
          end
        end
        S_SCAN: begin
          if (head_vld && !head_lt) seen_ge <= 1'b1;
          if (scan_idx == LAST) begin
            state     <= S_DRAIN;
            drain_cnt <= 1'b0;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_DRAIN: begin
          drain_cnt <= 1'b1;
          if (drain_cnt) state <= S_REPORT;
        end
        S_REPORT: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if (down_hit) begin
            result.status        <= ST_OK;
            result.found_tag     <= down_ent.tag;
            result.found_mass    <= down_ent.mass;
            result.found_segment <= down_ent.segment;
          end else if (up_hit) begin
            result.status        <= ST_OK;
            result.found_tag     <= up_ent.tag;
            result.found_mass    <= up_ent.mass;
            result.found_segment <= up_ent.segment;
          end else begin
            result.status <= ST_MISS;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/ptpm_props.sv @@
module ptpm_props #(
  parameter int ENTRIES = 256
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input ptpm_pkg::item_t   item,
  input logic              done,
  input ptpm_pkg::result_t result
);
  import ptpm_pkg::*;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  a_short_op: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op != OP_QUERY) |=> done)
    else $error("non-query item gave no result next cycle");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op == OP_QUERY) |=> (busy && !done))
    else $error("query did not hold busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |->
    (result.found_tag == '0 && result.found_mass == '0 && result.found_segment == '0))
    else $error("found fields set without a match");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(result.entry_count) <= ENTRIES))
    else $error("entry count beyond table size");

endmodule

bind ppm_tolerance_profile_matcher ptpm_props #(.ENTRIES(ENTRIES)) u_props (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
  .done(done), .result(result)
);
